### src/kmes_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmes_pkg
// Shared types, codes and helpers of the keypad matrix edge-event scanner.
// ----------------------------------------------------------------------------
package kmes_pkg;

	localparam int MAX_ROWS_DEF    = 8;
	localparam int MAX_COLUMNS_DEF = 8;
	localparam int COUNT_LIMIT     = 8;
	localparam int KEY_COUNT       = 64;
	localparam int KEY_W           = $clog2(KEY_COUNT);
	localparam int FLAG_W          = 3;
	localparam int CFG_IDX_W       = 1;
	localparam int CFG_DATA_W      = 4;

	// flag bit positions
	localparam int FLAG_DOWN = 0;
	localparam int FLAG_JP   = 1;
	localparam int FLAG_JR   = 2;

	localparam logic [1:0] REQ_SAMPLE = 2'd0;
	localparam logic [1:0] REQ_QUERY  = 2'd1;
	localparam logic [1:0] REQ_CLEAR  = 2'd2;

	localparam logic [1:0] KIND_PRESS   = 2'd0;
	localparam logic [1:0] KIND_RELEASE = 2'd1;
	localparam logic [1:0] KIND_REPLY   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 1'b1;

	localparam logic [CFG_DATA_W-1:0] COUNT_RESET = 4'd8;

	typedef struct packed {
		logic [1:0]       req_type;
		logic [2:0]       row_number;
		logic [7:0]       column_bits;
		logic [KEY_W-1:0] key_index;
		logic             clear_just_pressed;
		logic             clear_just_released;
	} kmes_in_t;

	typedef struct packed {
		logic [1:0]       result_kind;
		logic [KEY_W-1:0] event_key;
		logic             is_down;
		logic             was_just_pressed;
		logic             was_just_released;
		logic             last_of_run;
	} kmes_out_t;

	// what one column lane found for the current row
	typedef struct packed {
		logic              pending;
		logic [1:0]        kind;
		logic [KEY_W-1:0]  key;
		logic [FLAG_W-1:0] flags;
	} kmes_lane_t;

	// clamp a count register to 1 .. min(param, 8)
	function automatic logic [CFG_DATA_W-1:0] limit_count(input logic [CFG_DATA_W-1:0] v,
			input int param);
		int lim;
		int val;
		lim = (param < COUNT_LIMIT) ? param : COUNT_LIMIT;
		if (lim < 1) lim = 1;
		val = int'(v);
		if (val < 1) val = 1;
		if (val > lim) val = lim;
		return CFG_DATA_W'(val);
	endfunction

endpackage

### src/kmes_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmes_ram
// Generic memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module kmes_ram #(
	parameter int WIDTH = 3,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### src/kmes_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmes_lane
// One column lane: edge detect of one key against its stored flags.
// ----------------------------------------------------------------------------
module kmes_lane (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           clr,
	input  logic                           load,
	input  logic                           down,
	input  logic [kmes_pkg::KEY_W-1:0]     key,
	input  logic [kmes_pkg::FLAG_W-1:0]    flags_in,
	input  logic                           take,
	output kmes_pkg::kmes_lane_t           lane
);
	import kmes_pkg::*;

	logic              pend_q;
	logic [1:0]        kind_q;
	logic [KEY_W-1:0]  key_q;
	logic [FLAG_W-1:0] flags_q;

	logic              press;
	logic              release_evt;
	logic [FLAG_W-1:0] flags_nxt;

	always_comb begin
		press       = down && !flags_in[FLAG_DOWN];
		release_evt = !down && flags_in[FLAG_DOWN];
		flags_nxt   = flags_in;
		if (press) begin
			flags_nxt[FLAG_DOWN] = 1'b1;
			flags_nxt[FLAG_JP]   = 1'b1;
		end else if (release_evt) begin
			flags_nxt[FLAG_DOWN] = 1'b0;
			flags_nxt[FLAG_JR]   = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (clr || take) begin
			pend_q <= 1'b0;
		end else if (load) begin
			pend_q <= press || release_evt;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q  <= press ? KIND_PRESS : KIND_RELEASE;
			key_q   <= key;
			flags_q <= flags_nxt;
		end
	end

	assign lane = '{pending: pend_q, kind: kind_q, key: key_q, flags: flags_q};

endmodule

### src/kmes_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmes_merge
// Picks the lowest column lane with a pending event and builds its result.
// ----------------------------------------------------------------------------
module kmes_merge #(
	parameter int NUM_LANES = 8
) (
	input  kmes_pkg::kmes_lane_t   lanes [NUM_LANES],
	output logic [NUM_LANES-1:0]   pick,
	output logic                   found,
	output kmes_pkg::kmes_out_t    res
);
	import kmes_pkg::*;

	logic [NUM_LANES-1:0] pending;
	kmes_lane_t           sel;

	always_comb begin
		pick  = '0;
		found = 1'b0;
		sel   = '0;
		for (int i = 0; i < NUM_LANES; i++) begin
			pending[i] = lanes[i].pending;
			if (lanes[i].pending && !found) begin
				pick[i] = 1'b1;
				found   = 1'b1;
				sel     = lanes[i];
			end
		end
		res.result_kind       = sel.kind;
		res.event_key         = sel.key;
		res.is_down           = sel.flags[FLAG_DOWN];
		res.was_just_pressed  = sel.flags[FLAG_JP];
		res.was_just_released = sel.flags[FLAG_JR];
		// last when nothing else is left behind the picked lane
		res.last_of_run       = ~|(pending & ~pick);
	end

endmodule

### src/keypad_matrix_edge_event_scanner_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_matrix_edge_event_scanner_core
// Keypad row scanner: per-key pressed / just-pressed / just-released flags,
// press and release events per sampled row, key queries and clear-all.
//
//   channel   direction  handshake                 payload
//   request   in         start, busy               req (kmes_in_t)
//   result    out        result_valid (strobe)     result (kmes_out_t)
//   config    in         cfg_we                    cfg_index, cfg_data
//
// Row sample: the flag RAM has one read port, so the clamped count of columns
// is fetched one column per cycle into its lane in S_READ; after S_EVAL the
// events are emitted one per cycle in S_EMIT, each with result and write-back.
// Query: replied from S_QREPLY. Clear, ignored row or unused type: stays in S_IDLE.
// Reset clears all flags at once (valid bit per key), no clearing pass.
// Results are one-cycle strobes; the receiver cannot stall them.
// ----------------------------------------------------------------------------
module keypad_matrix_edge_event_scanner_core #(
	parameter int MAX_ROWS    = kmes_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLUMNS = kmes_pkg::MAX_COLUMNS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  kmes_pkg::kmes_in_t                req,
	output logic                              result_valid,
	output kmes_pkg::kmes_out_t               result,
	input  logic                              cfg_we,
	input  logic [kmes_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [kmes_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import kmes_pkg::*;

	localparam int NUM_LANES = (MAX_COLUMNS < COUNT_LIMIT) ? MAX_COLUMNS : COUNT_LIMIT;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_READ   = 5'b00010,
		S_EVAL   = 5'b00100,
		S_EMIT   = 5'b01000,
		S_QREPLY = 5'b10000
	} state_t;

	state_t                state_q;
	logic [CFG_DATA_W-1:0] rows_q;
	logic [CFG_DATA_W-1:0] cols_q;
	logic [CFG_DATA_W-1:0] rows_eff;
	logic [CFG_DATA_W-1:0] cols_eff;
	logic [CFG_DATA_W-1:0] col_q;
	logic [KEY_W-1:0]      addr_q;
	logic [KEY_COUNT-1:0]  valid_q;
	kmes_in_t              req_q;
	kmes_out_t             result_q;
	logic                  result_valid_q;

	logic                  ld_en_s1;
	logic [CFG_DATA_W-1:0] ld_col_s1;
	logic [KEY_W-1:0]      ld_key_s1;
	logic                  rd_valid_s1;

	logic                  accept;
	logic                  lane_clr;
	logic [KEY_W-1:0]      rd_addr;
	logic [FLAG_W-1:0]     rd_data;
	logic [FLAG_W-1:0]     rd_flags;
	logic [FLAG_W-1:0]     q_flags_wb;
	logic                  wr_en;
	logic [KEY_W-1:0]      wr_addr;
	logic [FLAG_W-1:0]     wr_data;

	kmes_lane_t            lanes [NUM_LANES];
	logic [NUM_LANES-1:0]  pick;
	logic                  found;
	kmes_out_t             merged;

	assign rows_eff = limit_count(rows_q, MAX_ROWS);
	assign cols_eff = limit_count(cols_q, MAX_COLUMNS);

	assign busy     = (state_q != S_IDLE);
	assign accept   = start && !busy;
	assign lane_clr = accept && (req.req_type == REQ_SAMPLE);

	// query read is issued straight from the request port
	assign rd_addr  = (state_q == S_IDLE) ? req.key_index : addr_q;
	assign rd_flags = rd_valid_s1 ? rd_data : '0;

	always_comb begin
		q_flags_wb = rd_flags;
		if (req_q.clear_just_pressed)  q_flags_wb[FLAG_JP] = 1'b0;
		if (req_q.clear_just_released) q_flags_wb[FLAG_JR] = 1'b0;
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = req_q.key_index;
		wr_data = q_flags_wb;
		if (state_q == S_EMIT) begin
			wr_en   = found;
			wr_addr = merged.event_key;
			wr_data = {merged.was_just_released, merged.was_just_pressed, merged.is_down};
		end else if (state_q == S_QREPLY) begin
			wr_en = 1'b1;
		end
	end

	kmes_ram #(
		.WIDTH(FLAG_W),
		.DEPTH(KEY_COUNT)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
		kmes_lane u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.clr     (lane_clr),
			.load    (ld_en_s1 && (ld_col_s1 == CFG_DATA_W'(i))),
			.down    (req_q.column_bits[i]),
			.key     (ld_key_s1),
			.flags_in(rd_flags),
			.take    ((state_q == S_EMIT) && pick[i]),
			.lane    (lanes[i])
		);
	end

	kmes_merge #(
		.NUM_LANES(NUM_LANES)
	) u_merge (
		.lanes(lanes),
		.pick (pick),
		.found(found),
		.res  (merged)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			rows_q         <= COUNT_RESET;
			cols_q         <= COUNT_RESET;
			col_q          <= '0;
			addr_q         <= '0;
			valid_q        <= '0;
			ld_en_s1       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			ld_en_s1       <= 1'b0;
			if (cfg_we) begin
				if (cfg_index == REG_ROWS) rows_q <= cfg_data;
				else if (cfg_index == REG_COLUMNS) cols_q <= cfg_data;
			end
			if (wr_en) valid_q[wr_addr] <= 1'b1;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req.req_type == REQ_SAMPLE) begin
							if ({1'b0, req.row_number} < rows_eff) begin
								addr_q  <= KEY_W'(req.row_number);
								col_q   <= '0;
								state_q <= S_READ;
							end
						end else if (req.req_type == REQ_QUERY) begin
							state_q <= S_QREPLY;
						end else if (req.req_type == REQ_CLEAR) begin
							valid_q <= '0;
						end
					end
				end
				S_READ: begin
					ld_en_s1 <= 1'b1;
					addr_q   <= addr_q + KEY_W'(rows_eff);
					col_q    <= col_q + CFG_DATA_W'(1);
					if (col_q == cols_eff - CFG_DATA_W'(1)) state_q <= S_EVAL;
				end
				S_EVAL: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (found) begin
						result_valid_q <= 1'b1;
						if (merged.last_of_run) state_q <= S_IDLE;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_QREPLY: begin
					result_valid_q <= 1'b1;
					state_q        <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_valid_s1 <= valid_q[rd_addr];
		ld_col_s1   <= col_q;
		ld_key_s1   <= addr_q;
		if (accept) req_q <= req;
		if (state_q == S_EMIT) begin
			result_q <= merged;
		end else if (state_q == S_QREPLY) begin
			result_q <= '{result_kind: KIND_REPLY, event_key: req_q.key_index,
				is_down: rd_flags[FLAG_DOWN], was_just_pressed: rd_flags[FLAG_JP],
				was_just_released: rd_flags[FLAG_JR], last_of_run: 1'b1};
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ($past(state_q) == S_EMIT || $past(state_q) == S_QREPLY))
		else $error("result strobe outside an emit or reply cycle");

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.last_of_run) |-> (state_q == S_IDLE))
		else $error("last result transferred but scanner still busy");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |-> (col_q < cols_eff))
		else $error("column fetch beyond columns in use");

	a_clear_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.req_type == REQ_CLEAR) |=> (!result_valid && !busy))
		else $error("clear request produced a result or stalled");

endmodule
